// ===== rtl/cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// cbs_pkg
// Types, codes and limits for the companion boot sequencer.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned VER_W      = 16;
  localparam int unsigned RETRY_W    = 6;
  localparam int unsigned REBOOT_W   = 3;

  localparam logic [RETRY_W-1:0]  POLL_LIMIT    = RETRY_W'(50);
  localparam logic [RETRY_W-1:0]  RETRY_MAX     = '1;
  localparam logic [RETRY_W-1:0]  MAX_DOWNLOADS = RETRY_W'(5);
  localparam logic [REBOOT_W-1:0] MAX_REBOOTS   = REBOOT_W'(5);
  localparam logic [REBOOT_W-1:0] REBOOT_MAX    = '1;

  typedef enum logic [9:0] {
    ST_BOOT       = 10'b00_0000_0001,
    ST_CHECKFAULT = 10'b00_0000_0010,
    ST_BOOTOK     = 10'b00_0000_0100,
    ST_UPDAPP     = 10'b00_0000_1000,
    ST_UPDSPI     = 10'b00_0001_0000,
    ST_STAGE1     = 10'b00_0010_0000,
    ST_SPIVERIFY  = 10'b00_0100_0000,
    ST_APPWAIT    = 10'b00_1000_0000,
    ST_READY      = 10'b01_0000_0000,
    ST_FAILED     = 10'b10_0000_0000
  } state_t;

  typedef enum logic [3:0] {
    CODE_BOOT       = 4'd0,
    CODE_CHECKFAULT = 4'd1,
    CODE_BOOTOK     = 4'd2,
    CODE_UPDAPP     = 4'd3,
    CODE_UPDSPI     = 4'd4,
    CODE_STAGE1     = 4'd5,
    CODE_SPIVERIFY  = 4'd6,
    CODE_APPWAIT    = 4'd7,
    CODE_READY      = 4'd8,
    CODE_FAILED     = 4'd9
  } state_code_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_LAUNCH = 2'd1,
    CMD_ENABLE = 2'd2,
    CMD_RESET  = 2'd3
  } sys_cmd_t;

  function automatic state_code_t state_code(input state_t s);
    state_code_t c;
    case (s)
      ST_BOOT:       c = CODE_BOOT;
      ST_CHECKFAULT: c = CODE_CHECKFAULT;
      ST_BOOTOK:     c = CODE_BOOTOK;
      ST_UPDAPP:     c = CODE_UPDAPP;
      ST_UPDSPI:     c = CODE_UPDSPI;
      ST_STAGE1:     c = CODE_STAGE1;
      ST_SPIVERIFY:  c = CODE_SPIVERIFY;
      ST_APPWAIT:    c = CODE_APPWAIT;
      ST_READY:      c = CODE_READY;
      default:       c = CODE_FAILED;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/companion_boot_sequencer.sv =====
// ----------------------------------------------------------------------------
// companion_boot_sequencer
// Steps a companion module through boot, verify, update and launch stages,
// one status snapshot per item, with timeouts and bounded reboots.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// in_      slave      tuser: cmd; tdata: status snapshot, version, download_ok
// out_     master     tdata: boot_state, sys_command, boot_done, boot_failed
// cfg_     write      expected_app_version
//
// One item per cycle while in_tready is high; its result is registered and shows in the next cycle.
// Sequencer state updates at the same edge the item is accepted.
// in_tready drops only while a result is held and out_tready is low.
// After reset the stage is failed until a start item arrives.
// ----------------------------------------------------------------------------
module companion_boot_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] magic_ok, [1] fault_flag, [2] ok_flag, [3] app_not_verified,
  // [4] app_verified, [5] stage1_flag, [6] spi_not_verified, [7] spi_verified,
  // [8] app_running, [24:9] reported_version, [25] download_ok
  input  logic [cbs_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] cmd
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] boot_state, [5:4] sys_command, [6] boot_done, [7] boot_failed
  output logic [cbs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [cbs_pkg::VER_W-1:0]       cfg_wr_data
);

  logic                              in_acc;
  logic                              magic_ok, fault_flag, ok_flag;
  logic                              app_not_verified, app_verified, stage1_flag;
  logic                              spi_not_verified, spi_verified, app_running;
  logic                              download_ok;
  logic [cbs_pkg::VER_W-1:0]         reported_version;

  cbs_pkg::state_t                   state_r, state_nxt;
  logic [cbs_pkg::RETRY_W-1:0]       retry_r, retry_nxt, retry_sat;
  logic [cbs_pkg::REBOOT_W-1:0]      reboot_r, reboot_nxt, reboot_inc;
  logic [cbs_pkg::VER_W-1:0]         exp_ver_r;
  cbs_pkg::sys_cmd_t                 cmd_nxt;
  logic                              timeout, fail;
  cbs_pkg::state_code_t              code_nxt;

  logic                              out_valid_r;
  logic [cbs_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign magic_ok         = in_tdata[0];
  assign fault_flag       = in_tdata[1];
  assign ok_flag          = in_tdata[2];
  assign app_not_verified = in_tdata[3];
  assign app_verified     = in_tdata[4];
  assign stage1_flag      = in_tdata[5];
  assign spi_not_verified = in_tdata[6];
  assign spi_verified     = in_tdata[7];
  assign app_running      = in_tdata[8];
  assign reported_version = in_tdata[24:9];
  assign download_ok      = in_tdata[25];

  assign timeout    = retry_r >= cbs_pkg::POLL_LIMIT;
  assign retry_sat  = retry_r + {{(cbs_pkg::RETRY_W-1){1'b0}},
                                 (retry_r != cbs_pkg::RETRY_MAX)};
  assign reboot_inc = reboot_r + {{(cbs_pkg::REBOOT_W-1){1'b0}},
                                  (reboot_r != cbs_pkg::REBOOT_MAX)};

  always_comb begin
    state_nxt  = state_r;
    retry_nxt  = retry_r;
    reboot_nxt = reboot_r;
    cmd_nxt    = cbs_pkg::CMD_NONE;
    fail       = 1'b0;
    if (in_tuser) begin
      reboot_nxt = '0;
      retry_nxt  = '0;
      state_nxt  = cbs_pkg::ST_BOOT;
    end else begin
      case (state_r)
        cbs_pkg::ST_BOOT: begin
          if (magic_ok) begin
            state_nxt = cbs_pkg::ST_CHECKFAULT;
            retry_nxt = '0;
          end else if (timeout) begin
            fail = 1'b1;
          end else begin
            retry_nxt = retry_sat;
          end
        end
        cbs_pkg::ST_CHECKFAULT: begin
          if (timeout || fault_flag) begin
            fail = 1'b1;
          end else if (ok_flag) begin
            state_nxt = cbs_pkg::ST_BOOTOK;
            retry_nxt = '0;
          end else begin
            retry_nxt = retry_sat;
          end
        end
        cbs_pkg::ST_BOOTOK: begin
          if (timeout) begin
            fail = 1'b1;
          end else if (app_not_verified) begin
            state_nxt = cbs_pkg::ST_UPDAPP;
            retry_nxt = '0;
          end else if (app_verified) begin
            retry_nxt = '0;
            if (reported_version == exp_ver_r) begin
              cmd_nxt   = cbs_pkg::CMD_LAUNCH;
              state_nxt = cbs_pkg::ST_STAGE1;
            end else begin
              state_nxt = cbs_pkg::ST_UPDAPP;
            end
          end else begin
            retry_nxt = retry_sat;
          end
        end
        cbs_pkg::ST_UPDAPP, cbs_pkg::ST_UPDSPI: begin
          if (download_ok) begin
            cmd_nxt   = cbs_pkg::CMD_RESET;
            state_nxt = cbs_pkg::ST_BOOT;
            retry_nxt = '0;
          end else if (retry_sat > cbs_pkg::MAX_DOWNLOADS) begin
            fail = 1'b1;
          end else begin
            retry_nxt = retry_sat;
          end
        end
        cbs_pkg::ST_STAGE1: begin
          if (magic_ok && stage1_flag) begin
            state_nxt = cbs_pkg::ST_SPIVERIFY;
            retry_nxt = '0;
          end else if (timeout) begin
            fail = 1'b1;
          end else begin
            retry_nxt = retry_sat;
          end
        end
        cbs_pkg::ST_SPIVERIFY: begin
          if (timeout) begin
            fail = 1'b1;
          end else if (spi_not_verified) begin
            state_nxt = cbs_pkg::ST_UPDSPI;
            retry_nxt = '0;
          end else if (spi_verified) begin
            cmd_nxt   = cbs_pkg::CMD_ENABLE;
            state_nxt = cbs_pkg::ST_APPWAIT;
            retry_nxt = '0;
          end else begin
            retry_nxt = retry_sat;
          end
        end
        cbs_pkg::ST_APPWAIT: begin
          if (magic_ok && app_running) begin
            state_nxt = cbs_pkg::ST_READY;
            retry_nxt = '0;
          end else if (timeout) begin
            fail = 1'b1;
          end else begin
            retry_nxt = retry_sat;
          end
        end
        cbs_pkg::ST_READY, cbs_pkg::ST_FAILED: begin
          state_nxt = state_r;
        end
        default: begin
          state_nxt = cbs_pkg::ST_FAILED;
        end
      endcase
      if (fail) begin
        reboot_nxt = reboot_inc;
        retry_nxt  = '0;
        if (reboot_inc > cbs_pkg::MAX_REBOOTS) begin
          state_nxt = cbs_pkg::ST_FAILED;
        end else begin
          cmd_nxt   = cbs_pkg::CMD_RESET;
          state_nxt = cbs_pkg::ST_BOOT;
        end
      end
    end
  end

  assign code_nxt     = cbs_pkg::state_code(state_nxt);
  assign out_data_nxt = {(code_nxt == cbs_pkg::CODE_FAILED),
                         (code_nxt == cbs_pkg::CODE_READY),
                         cmd_nxt, code_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbs_pkg::ST_FAILED;
      retry_r     <= '0;
      reboot_r    <= '0;
      exp_ver_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        exp_ver_r <= cfg_wr_data;
      end
      if (in_acc) begin
        state_r  <= state_nxt;
        retry_r  <= retry_nxt;
        reboot_r <= reboot_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted item produced no result");

  a_done_fail_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[6] && out_tdata[7]))
    else $error("boot_done and boot_failed both set");

  a_launch_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[5:4] == cbs_pkg::CMD_LAUNCH)
      |-> out_tdata[3:0] == cbs_pkg::CODE_STAGE1)
    else $error("launch without entering stage1");

  a_reset_boot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[5:4] == cbs_pkg::CMD_RESET)
      |-> out_tdata[3:0] == cbs_pkg::CODE_BOOT)
    else $error("reset command without return to boot");

  a_reboot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (reboot_r > cbs_pkg::MAX_REBOOTS) |-> (state_r == cbs_pkg::ST_FAILED))
    else $error("reboot limit passed but not failed");

endmodule
